>>> src/three_bus_datapath_step_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-bus datapath step
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef THREE_BUS_DATAPATH_STEP_ASSERT_SVH
`define THREE_BUS_DATAPATH_STEP_ASSERT_SVH

`ifndef ASSERT_OFF
`define TBDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define TBDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TBDS_ASSERT_IMP(lbl, ante, cons, msg)
`define TBDS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> src/tbds_pkg.sv
// ----------------------------------------------------------------------------
// tbds_pkg
// Shared types, codes and helpers of the three-bus datapath step.
// ----------------------------------------------------------------------------
package tbds_pkg;

  localparam int DATA_W      = 32;
  localparam int PC_W        = 8;
  localparam int ADDR_W      = 8;
  localparam int REG_FIELD_W = 3;
  localparam int REG_IDX_W   = 5;   // enough for up to 32 registers
  localparam int LABEL_W     = 2;
  localparam int MAX_LABELS  = 4;
  localparam int S_TDATA_W   = 32;
  localparam int M_TDATA_W   = 80;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_LABEL_ADDR_BASE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LABEL_MASK      = 3'd4;

  localparam int DEF_NUM_REGS   = 8;
  localparam int DEF_MEM_WORDS  = 16;
  localparam int DEF_NUM_LABELS = 4;

  typedef enum logic [2:0] {
    FUNC_COPY,
    FUNC_LOAD,
    FUNC_STORE,
    FUNC_ALU,
    FUNC_FETCH,
    FUNC_DECODE,
    FUNC_EXECUTE,
    FUNC_BRANCH
  } func_t;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_NOT
  } alu_op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_ADDR,
    ST_NO_LABEL
  } status_t;

  typedef struct packed {
    logic              hit;
    logic [PC_W-1:0]   target;
  } branch_t;

  // decoded word handed from issue to execute
  typedef struct packed {
    func_t                 func;
    logic [REG_IDX_W-1:0]  ra;
    logic [REG_IDX_W-1:0]  rb;
    logic [REG_IDX_W-1:0]  rd;
    logic [ADDR_W-1:0]     addr;   // load/store address, or PC for fetch
    alu_op_t               alu_op;
    status_t               status;
    logic [PC_W-1:0]       pc;     // PC after this word
  } issue_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  bus_value;
    logic [PC_W-1:0]           pc_now;
    logic signed [DATA_W-1:0]  ir_now;
  } result_t;

  // register field taken modulo the register count (n >= 2)
  function automatic logic [REG_IDX_W-1:0] reg_sel(input logic [REG_FIELD_W-1:0] v,
                                                   input int unsigned n);
    logic [REG_IDX_W-1:0] r;
    r = REG_IDX_W'(v);
    for (int k = 0; k < 4; k++) begin
      if (32'(r) >= n) begin
        r = r - REG_IDX_W'(n);
      end
    end
    return r;
  endfunction

endpackage

>>> src/three_bus_datapath_step.sv
// ----------------------------------------------------------------------------
// three_bus_datapath_step: one control word per cycle on a small datapath
// unless the output stalls. Words are registered in execute, then in skid.
// Throughput is set by the single execute stage with its forwarded reads.
// Sync reset clears register and memory valid bits, PC, IR and label config.
// ----------------------------------------------------------------------------
module three_bus_datapath_step #(
  parameter int NUM_REGS   = tbds_pkg::DEF_NUM_REGS,
  parameter int MEM_WORDS  = tbds_pkg::DEF_MEM_WORDS,
  parameter int NUM_LABELS = tbds_pkg::DEF_NUM_LABELS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // func, src_a, src_b, dest, mem_address, alu_op, label_index, zero pad
  input  logic [tbds_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status, bus_value, pc_now, ir_now, zero pad
  output logic [tbds_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                              cfg_we,
  input  logic [tbds_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tbds_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic               accept;
  logic               exec_valid;
  logic               out_ready;
  tbds_pkg::branch_t  br;
  tbds_pkg::issue_t   iss;
  tbds_pkg::result_t  res;
  tbds_pkg::result_t  out_res;

  assign s_tready = !exec_valid || out_ready;
  assign accept   = s_tvalid && s_tready;

  tbds_cfg #(
    .NUM_LABELS (NUM_LABELS)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .label_index (s_tdata[24:23]),
    .br          (br)
  );

  tbds_issue #(
    .NUM_REGS  (NUM_REGS),
    .MEM_WORDS (MEM_WORDS)
  ) u_issue (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .func        (tbds_pkg::func_t'(s_tdata[2:0])),
    .src_a       (s_tdata[5:3]),
    .src_b       (s_tdata[8:6]),
    .dest        (s_tdata[11:9]),
    .mem_address (s_tdata[19:12]),
    .alu_op      (tbds_pkg::alu_op_t'(s_tdata[22:20])),
    .br          (br),
    .iss         (iss)
  );

  tbds_exec #(
    .NUM_REGS  (NUM_REGS),
    .MEM_WORDS (MEM_WORDS)
  ) u_exec (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .iss       (iss),
    .out_ready (out_ready),
    .valid     (exec_valid),
    .res       (res)
  );

  tbds_skid #(
    .W ($bits(tbds_pkg::result_t))
  ) u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (exec_valid),
    .in_ready  (out_ready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {6'd0, out_res.ir_now, out_res.pc_now, out_res.bus_value,
                    out_res.status};

endmodule

>>> src/tbds_cfg.sv
// ----------------------------------------------------------------------------
// tbds_cfg
// Branch label registers and the label lookup for the issue stage.
// ----------------------------------------------------------------------------
module tbds_cfg #(
  parameter int NUM_LABELS = tbds_pkg::DEF_NUM_LABELS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tbds_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tbds_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [tbds_pkg::LABEL_W-1:0]        label_index,
  output tbds_pkg::branch_t                   br
);

  logic [tbds_pkg::PC_W-1:0] label_addr [NUM_LABELS];
  logic [NUM_LABELS-1:0]     label_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      label_mask <= '0;
      for (int i = 0; i < NUM_LABELS; i++) begin
        label_addr[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == tbds_pkg::CFG_LABEL_MASK) begin
        label_mask <= cfg_data[NUM_LABELS-1:0];
      end
      for (int i = 0; i < NUM_LABELS; i++) begin
        if (cfg_index == tbds_pkg::CFG_LABEL_ADDR_BASE + tbds_pkg::CFG_INDEX_W'(i)) begin
          label_addr[i] <= cfg_data[tbds_pkg::PC_W-1:0];
        end
      end
    end
  end

  // labels at or past NUM_LABELS never hit
  always_comb begin
    br.hit    = 1'b0;
    br.target = '0;
    for (int i = 0; i < NUM_LABELS; i++) begin
      if (label_index == tbds_pkg::LABEL_W'(i)) begin
        br.hit    = label_mask[i];
        br.target = label_addr[i];
      end
    end
  end

endmodule

>>> src/tbds_issue.sv
// ----------------------------------------------------------------------------
// tbds_issue
// Decodes the incoming word, checks addresses and labels, owns the PC.
// ----------------------------------------------------------------------------
module tbds_issue #(
  parameter int NUM_REGS  = tbds_pkg::DEF_NUM_REGS,
  parameter int MEM_WORDS = tbds_pkg::DEF_MEM_WORDS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  tbds_pkg::func_t                     func,
  input  logic [tbds_pkg::REG_FIELD_W-1:0]    src_a,
  input  logic [tbds_pkg::REG_FIELD_W-1:0]    src_b,
  input  logic [tbds_pkg::REG_FIELD_W-1:0]    dest,
  input  logic [tbds_pkg::ADDR_W-1:0]         mem_address,
  input  tbds_pkg::alu_op_t                   alu_op,
  input  tbds_pkg::branch_t                   br,
  output tbds_pkg::issue_t                    iss
);

  logic [tbds_pkg::PC_W-1:0] pc;
  logic [tbds_pkg::PC_W-1:0] pc_next;
  logic                      addr_ok;
  logic                      pc_ok;

  assign addr_ok = {1'b0, mem_address} < (tbds_pkg::ADDR_W + 1)'(MEM_WORDS);
  assign pc_ok   = {1'b0, pc} < (tbds_pkg::PC_W + 1)'(MEM_WORDS);

  always_comb begin
    pc_next    = pc;
    iss.status = tbds_pkg::ST_OK;
    iss.addr   = mem_address;
    unique case (func)
      tbds_pkg::FUNC_LOAD, tbds_pkg::FUNC_STORE: begin
        if (!addr_ok) iss.status = tbds_pkg::ST_BAD_ADDR;
      end
      tbds_pkg::FUNC_FETCH: begin
        // PC advances even when it points past the memory
        iss.addr = pc;
        pc_next  = pc + 8'd1;
        if (!pc_ok) iss.status = tbds_pkg::ST_BAD_ADDR;
      end
      tbds_pkg::FUNC_BRANCH: begin
        if (br.hit) pc_next = br.target;
        else        iss.status = tbds_pkg::ST_NO_LABEL;
      end
      default: ;
    endcase
    iss.func   = func;
    iss.ra     = tbds_pkg::reg_sel(src_a, NUM_REGS);
    iss.rb     = tbds_pkg::reg_sel(src_b, NUM_REGS);
    iss.rd     = tbds_pkg::reg_sel(dest, NUM_REGS);
    iss.alu_op = alu_op;
    iss.pc     = pc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (accept) begin
      pc <= pc_next;
    end
  end

endmodule

>>> src/tbds_exec.sv
// ----------------------------------------------------------------------------
// tbds_exec
// Execute stage: register file, data memory, IR, ALU and write-back.
// ----------------------------------------------------------------------------
`include "three_bus_datapath_step_assert.svh"

module tbds_exec #(
  parameter int NUM_REGS  = tbds_pkg::DEF_NUM_REGS,
  parameter int MEM_WORDS = tbds_pkg::DEF_MEM_WORDS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  tbds_pkg::issue_t   iss,
  input  logic               out_ready,
  output logic               valid,
  output tbds_pkg::result_t  res
);

  localparam int RW = $clog2(NUM_REGS);
  localparam int AW = $clog2(MEM_WORDS);

  tbds_pkg::issue_t            op_q;
  logic [tbds_pkg::DATA_W-1:0] a_q;
  logic [tbds_pkg::DATA_W-1:0] b_q;
  logic [tbds_pkg::DATA_W-1:0] m_q;
  logic [tbds_pkg::DATA_W-1:0] ir;

  logic [tbds_pkg::DATA_W-1:0] rf [NUM_REGS];
  logic [NUM_REGS-1:0]         rf_vld;
  logic [tbds_pkg::DATA_W-1:0] dm [MEM_WORDS];
  logic [MEM_WORDS-1:0]        dm_vld;

  logic                        fire;
  logic                        ok;
  logic [tbds_pkg::DATA_W-1:0] bus;
  logic                        rf_we;
  logic                        dm_we;
  logic                        ir_we;
  logic                        rf_wen;
  logic                        dm_wen;
  logic                        ir_wen;
  logic [RW-1:0]               rf_wi;
  logic [AW-1:0]               dm_wi;
  logic [RW-1:0]               ra_i;
  logic [RW-1:0]               rb_i;
  logic [AW-1:0]               mi;

  assign fire = valid && out_ready;
  assign ok   = (op_q.status == tbds_pkg::ST_OK);

  always_comb begin
    bus   = '0;
    rf_we = 1'b0;
    dm_we = 1'b0;
    ir_we = 1'b0;
    unique case (op_q.func)
      tbds_pkg::FUNC_COPY: begin
        bus   = a_q;
        rf_we = 1'b1;
      end
      tbds_pkg::FUNC_LOAD: begin
        if (ok) begin
          bus   = m_q;
          rf_we = 1'b1;
        end
      end
      tbds_pkg::FUNC_STORE: begin
        if (ok) begin
          bus   = a_q;
          dm_we = 1'b1;
        end
      end
      tbds_pkg::FUNC_ALU: begin
        unique case (op_q.alu_op)
          tbds_pkg::ALU_ADD: begin bus = a_q + b_q; rf_we = 1'b1; end
          tbds_pkg::ALU_SUB: begin bus = a_q - b_q; rf_we = 1'b1; end
          tbds_pkg::ALU_AND: begin bus = a_q & b_q; rf_we = 1'b1; end
          tbds_pkg::ALU_OR:  begin bus = a_q | b_q; rf_we = 1'b1; end
          tbds_pkg::ALU_NOT: begin bus = ~a_q;      rf_we = 1'b1; end
          default: ;  // unused op codes: no write, bus zero
        endcase
      end
      tbds_pkg::FUNC_FETCH: begin
        if (ok) begin
          bus   = m_q;
          ir_we = 1'b1;
        end
      end
      tbds_pkg::FUNC_BRANCH: begin
        if (ok) bus = tbds_pkg::DATA_W'(op_q.pc);
      end
      default: ;  // decode, execute
    endcase
  end

  assign rf_wen = fire && rf_we;
  assign dm_wen = fire && dm_we;
  assign ir_wen = fire && ir_we;
  assign rf_wi  = op_q.rd[RW-1:0];
  assign dm_wi  = op_q.addr[AW-1:0];
  assign ra_i   = iss.ra[RW-1:0];
  assign rb_i   = iss.rb[RW-1:0];
  assign mi     = iss.addr[AW-1:0];

  // Registered reads; the word now in execute writes in the same cycle,
  // so its write data is forwarded into the read registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= iss;
      if (rf_wen && rf_wi == ra_i) a_q <= bus;
      else if (rf_vld[ra_i])       a_q <= rf[ra_i];
      else                         a_q <= '0;
      if (rf_wen && rf_wi == rb_i) b_q <= bus;
      else if (rf_vld[rb_i])       b_q <= rf[rb_i];
      else                         b_q <= '0;
      if (dm_wen && dm_wi == mi)   m_q <= a_q;
      else if (dm_vld[mi])         m_q <= dm[mi];
      else                         m_q <= '0;
    end
    if (rf_wen) rf[rf_wi] <= bus;
    if (dm_wen) dm[dm_wi] <= a_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      rf_vld <= '0;
      dm_vld <= '0;
      ir     <= '0;
    end else begin
      if (accept)    valid <= 1'b1;
      else if (fire) valid <= 1'b0;
      if (rf_wen) rf_vld[rf_wi] <= 1'b1;
      if (dm_wen) dm_vld[dm_wi] <= 1'b1;
      if (ir_wen) ir <= m_q;
    end
  end

  assign res.status    = op_q.status;
  assign res.bus_value = bus;
  assign res.pc_now    = op_q.pc;
  assign res.ir_now    = ir_we ? m_q : ir;

  `TBDS_ASSERT_IMP(a_err_bus_zero, valid && !ok, bus == '0, "error word with nonzero bus")
  `TBDS_ASSERT_IMP(a_fetch_ir, valid && ir_we, res.ir_now == res.bus_value, "fetch IR mismatch")
  `TBDS_ASSERT_NXT(a_stall_hold, valid && !out_ready, valid && $stable(op_q), "stalled word lost")
  `TBDS_ASSERT_NXT(a_ir_hold, !ir_wen, $stable(ir), "IR changed without fetch")

endmodule

>>> src/tbds_skid.sv
// ----------------------------------------------------------------------------
// tbds_skid
// Two-entry output skid buffer; ready toward the source is registered.
// ----------------------------------------------------------------------------
module tbds_skid #(
  parameter int W = $bits(tbds_pkg::result_t)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         skid_valid;
  logic [W-1:0] skid_data;
  logic         in_fire;
  logic         main_free;

  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign main_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid)   out_data <= skid_data;
      else if (in_fire) out_data <= in_data;
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

endmodule
